>>> design/ipds_pkg.sv
// shared types and constants for the image pair difference statistics block
`timescale 1ns / 1ps
`default_nettype none

package ipds_pkg;

   localparam int MAX_DIM      = 4096;
   localparam int MAX_CHANNELS = 4;

   localparam int DIM_W    = 13;
   localparam int POS_W    = 12;
   localparam int CHAN_W   = 3;
   localparam int TOL_W    = 8;
   localparam int PIXEL_W  = 32;
   localparam int COUNT_W  = 25;
   localparam int FRAC_W   = 17;
   localparam int TOTAL_W  = 25;
   localparam int REM_W    = TOTAL_W + 1;
   localparam int DIV_STEPS = FRAC_W;
   localparam int STEP_W   = $clog2(DIV_STEPS);
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = DIM_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [POS_W-1:0]   POS_ALL_ONES = '1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FRAME_WIDTH       = 2'd0,
      REG_FRAME_HEIGHT      = 2'd1,
      REG_CHANNEL_COUNT     = 2'd2,
      REG_CHANNEL_TOLERANCE = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_a;
      logic [PIXEL_W-1:0] pixel_b;
   } req_data_type;

   typedef struct packed {
      logic [COUNT_W-1:0] diff_count;
      logic               has_box;
      logic [POS_W-1:0]   box_x;
      logic [POS_W-1:0]   box_y;
      logic [DIM_W-1:0]   box_width;
      logic [DIM_W-1:0]   box_height;
      logic [FRAC_W-1:0]  match_fraction;
   } rsp_data_type;

   // effective configuration, already clamped
   typedef struct packed {
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
      logic [CHAN_W-1:0] channels;
      logic [TOL_W-1:0]  tolerance;
   } cfg_type;

   typedef struct packed {
      logic pixel_take;
      logic calc_total;
      logic div_init;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic frame_end;
   } status_type;

endpackage

`default_nettype wire

>>> design/ipds_csr.sv
// configuration registers with clamping of the programmed values
`timescale 1ns / 1ps
`default_nettype none

module ipds_csr (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [ipds_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [ipds_pkg::CSR_DATA_W-1:0]    csr_data,
   output ipds_pkg::cfg_type                  cfg
);
   import ipds_pkg::*;

   localparam logic [DIM_W-1:0]  DIM_LIMIT  = DIM_W'(MAX_DIM);
   localparam logic [CHAN_W-1:0] CHAN_LIMIT = CHAN_W'(MAX_CHANNELS);

   logic [DIM_W-1:0]  width_ff, width_in;
   logic [DIM_W-1:0]  height_ff, height_in;
   logic [CHAN_W-1:0] chan_ff, chan_in;
   logic [TOL_W-1:0]  tol_ff, tol_in;
   logic              write_en;

   assign csr_ready = 1'b1;
   assign write_en  = csr_valid & csr_ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      chan_in   = chan_ff;
      tol_in    = tol_ff;
      if (write_en) begin
         case (reg_index_type'(csr_index))
            REG_FRAME_WIDTH:       width_in  = csr_data;
            REG_FRAME_HEIGHT:      height_in = csr_data;
            REG_CHANNEL_COUNT:     chan_in   = csr_data[CHAN_W-1:0];
            REG_CHANNEL_TOLERANCE: tol_in    = csr_data[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_LIMIT;
         height_ff <= DIM_LIMIT;
         chan_ff   <= CHAN_LIMIT;
         tol_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         chan_ff   <= chan_in;
         tol_ff    <= tol_in;
      end
   end

   // zero width or height counts as one; oversize dimensions and channel counts as the limit
   always_comb begin
      if (width_ff == '0)
         cfg.width = DIM_W'(1);
      else if (width_ff > DIM_LIMIT)
         cfg.width = DIM_LIMIT;
      else
         cfg.width = width_ff;

      if (height_ff == '0)
         cfg.height = DIM_W'(1);
      else if (height_ff > DIM_LIMIT)
         cfg.height = DIM_LIMIT;
      else
         cfg.height = height_ff;

      cfg.channels  = (chan_ff > CHAN_LIMIT) ? CHAN_LIMIT : chan_ff;
      cfg.tolerance = tol_ff;
   end

endmodule

`default_nettype wire

>>> design/ipds_ctrl.sv
// controller: pixel accumulation, frame-end product, divider sequencing, result handoff
`timescale 1ns / 1ps
`default_nettype none

module ipds_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   input  ipds_pkg::status_type    status,
   output ipds_pkg::cmd_type       cmd
);
   import ipds_pkg::*;

   typedef enum logic [4:0] {
      ST_ACCUM   = 5'b00001,
      ST_PRODUCT = 5'b00010,
      ST_PREP    = 5'b00100,
      ST_DIVIDE  = 5'b01000,
      ST_LOAD    = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign req_ready = (state_ff == ST_ACCUM);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_ACCUM: begin
            if (req_valid) begin
               cmd.pixel_take = 1'b1;
               if (status.frame_end)
                  state_in = ST_PRODUCT;
            end
         end
         ST_PRODUCT: begin
            cmd.calc_total = 1'b1;
            state_in       = ST_PREP;
         end
         ST_PREP: begin
            cmd.div_init = 1'b1;
            step_in      = STEP_W'(DIV_STEPS - 1);
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0)
               state_in = ST_LOAD;
            else
               step_in = step_ff - 1'b1;
         end
         ST_LOAD: begin
            // wait for the previous result beat to leave the output register
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_ACCUM;
            end
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> design/ipds_datapath.sv
// datapath: pixel compare, counters, bounding box, total product, restoring divider, output register
`timescale 1ns / 1ps
`default_nettype none

module ipds_datapath (
   input  wire                       clock,
   input  wire                       reset,
   input  ipds_pkg::cfg_type         cfg,
   input  ipds_pkg::req_data_type    req_data,
   input  ipds_pkg::cmd_type         cmd,
   output ipds_pkg::status_type      status,
   output ipds_pkg::rsp_data_type    rsp_data
);
   import ipds_pkg::*;

   logic [POS_W-1:0]   column_ff, column_in;
   logic [POS_W-1:0]   row_ff, row_in;
   logic [COUNT_W-1:0] total_diff_ff, total_diff_in;
   logic [POS_W-1:0]   min_col_ff, min_col_in;
   logic [POS_W-1:0]   min_row_ff, min_row_in;
   logic [POS_W-1:0]   max_col_ff, max_col_in;
   logic [POS_W-1:0]   max_row_ff, max_row_in;

   logic [TOTAL_W-1:0] total_ff;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [FRAC_W-1:0]  quot_ff, quot_in;
   rsp_data_type       out_ff, out_in;

   logic [MAX_CHANNELS-1:0] lane_hit;
   logic                    pixel_mismatch;
   logic                    last_col, last_row, first_hit;
   logic [2*DIM_W-1:0]      product;
   logic [TOTAL_W-1:0]      diff_wide, matching;
   logic [REM_W-1:0]        rem_sub;
   logic                    rem_ge;
   logic                    has;

   // per-channel absolute difference against the tolerance
   always_comb begin
      logic [7:0] byte_a;
      logic [7:0] byte_b;
      logic [7:0] byte_d;
      for (int k = 0; k < MAX_CHANNELS; k++) begin
         byte_a = req_data.pixel_a[8*k +: 8];
         byte_b = req_data.pixel_b[8*k +: 8];
         byte_d = (byte_a > byte_b) ? (byte_a - byte_b) : (byte_b - byte_a);
         lane_hit[k] = (CHAN_W'(k) < cfg.channels) && (byte_d > cfg.tolerance);
      end
   end

   assign pixel_mismatch = |lane_hit;
   assign last_col  = {1'b0, column_ff} >= (cfg.width - DIM_W'(1));
   assign last_row  = {1'b0, row_ff} >= (cfg.height - DIM_W'(1));
   assign status.frame_end = last_col & last_row;
   assign first_hit = (total_diff_ff == '0);

   assign product   = cfg.width * cfg.height;
   assign diff_wide = TOTAL_W'(total_diff_ff);
   assign matching  = (diff_wide >= total_ff) ? '0 : (total_ff - diff_wide);
   assign rem_ge    = rem_ff >= {1'b0, total_ff};
   assign rem_sub   = rem_ge ? (rem_ff - {1'b0, total_ff}) : rem_ff;
   assign has       = ~first_hit;

   always_comb begin
      column_in     = column_ff;
      row_in        = row_ff;
      total_diff_in = total_diff_ff;
      min_col_in    = min_col_ff;
      min_row_in    = min_row_ff;
      max_col_in    = max_col_ff;
      max_row_in    = max_row_ff;

      if (cmd.pixel_take) begin
         if (pixel_mismatch) begin
            if (total_diff_ff != COUNT_MAX)
               total_diff_in = total_diff_ff + 1'b1;
            if (first_hit || column_ff < min_col_ff) min_col_in = column_ff;
            if (first_hit || row_ff < min_row_ff)    min_row_in = row_ff;
            if (first_hit || column_ff > max_col_ff) max_col_in = column_ff;
            if (first_hit || row_ff > max_row_ff)    max_row_in = row_ff;
         end
         if (!last_col) begin
            column_in = column_ff + 1'b1;
         end else if (!last_row) begin
            column_in = '0;
            row_in    = row_ff + 1'b1;
         end
      end

      // frame statistics restart once the result is captured
      if (cmd.out_load) begin
         column_in     = '0;
         row_in        = '0;
         total_diff_in = '0;
         min_col_in    = POS_ALL_ONES;
         min_row_in    = POS_ALL_ONES;
         max_col_in    = '0;
         max_row_in    = '0;
      end
   end

   // restoring division, one quotient bit per step, msb first
   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (cmd.div_init) begin
         rem_in  = {1'b0, matching};
         quot_in = '0;
      end else if (cmd.div_step) begin
         rem_in  = {rem_sub[REM_W-2:0], 1'b0};
         quot_in = {quot_ff[FRAC_W-2:0], rem_ge};
      end
   end

   always_comb begin
      out_in = out_ff;
      if (cmd.out_load) begin
         out_in.diff_count     = total_diff_ff;
         out_in.has_box        = has;
         out_in.box_x          = has ? min_col_ff : '0;
         out_in.box_y          = has ? min_row_ff : '0;
         out_in.box_width      = has ? ({1'b0, max_col_ff} - {1'b0, min_col_ff} + DIM_W'(1))
                                     : '0;
         out_in.box_height     = has ? ({1'b0, max_row_ff} - {1'b0, min_row_ff} + DIM_W'(1))
                                     : '0;
         out_in.match_fraction = quot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= '0;
         row_ff        <= '0;
         total_diff_ff <= '0;
         min_col_ff    <= POS_ALL_ONES;
         min_row_ff    <= POS_ALL_ONES;
         max_col_ff    <= '0;
         max_row_ff    <= '0;
      end else begin
         column_ff     <= column_in;
         row_ff        <= row_in;
         total_diff_ff <= total_diff_in;
         min_col_ff    <= min_col_in;
         min_row_ff    <= min_row_in;
         max_col_ff    <= max_col_in;
         max_row_ff    <= max_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc_total)
         total_ff <= product[TOTAL_W-1:0];
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      out_ff  <= out_in;
   end

   assign rsp_data = out_ff;

endmodule

`default_nettype wire

>>> design/image_pair_diff_stats_top.sv
// top level of the image pair difference statistics block
// Usage: pixel pairs of two frames arrive in raster order on req_* (valid/ready),
// one beat per pixel; the block keeps its own column and row counters.
// Frame geometry, channel count and tolerance are written on csr_* by register index;
// csr_ready is always high and writes take effect at once.
// Throughput: one pixel beat per cycle while a frame streams in.
// After the last pixel of a frame the block accepts no pixels while it forms
// the width by height product, sets up the divider, runs the restoring divider
// (one quotient bit per cycle) and loads the output register; rsp_valid rises
// as the output register is loaded.
// The result sits in an output register; the next frame streams in while it
// waits. If the receiver still holds the previous result when a frame ends,
// the block waits with req_ready low until that beat is taken.
// Reset restores the register defaults (4096 x 4096, four channels, tolerance 0)
// and clears the frame counters and statistics; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module image_pair_diff_stats_top (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  ipds_pkg::req_data_type             req_data,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output ipds_pkg::rsp_data_type             rsp_data,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [ipds_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [ipds_pkg::CSR_DATA_W-1:0]    csr_data
);
   import ipds_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   ipds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ipds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ipds_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

>>> test/image_pair_diff_stats_top_test.sv
// self-checking testbench for the image pair difference statistics block
`timescale 1ns / 1ps

module image_pair_diff_stats_top_test;
   import ipds_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 40;
   localparam int LONG_HOLD   = 400;

   // expected frame statistics, built pixel by pixel as beats are accepted
   class frame_stats_board;
      int unsigned width_reg, height_reg, chan_reg, tol_reg;
      int unsigned col, row, differ, min_c, min_r, max_c, max_r;
      rsp_data_type frame_results[$];
      int unsigned errors;
      int unsigned checked;

      function new();
         width_reg  = MAX_DIM;
         height_reg = MAX_DIM;
         chan_reg   = MAX_CHANNELS;
         tol_reg    = 0;
         errors     = 0;
         checked    = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         col    = 0;
         row    = 0;
         differ = 0;
         min_c  = POS_ALL_ONES;
         min_r  = POS_ALL_ONES;
         max_c  = 0;
         max_r  = 0;
      endfunction

      function int unsigned eff_dim(int unsigned v);
         if (v == 0) return 1;
         if (v > MAX_DIM) return MAX_DIM;
         return v;
      endfunction

      function int unsigned frame_pixels();
         return eff_dim(width_reg) * eff_dim(height_reg);
      endfunction

      function int unsigned pending();
         return frame_results.size();
      endfunction

      function void write_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            REG_FRAME_WIDTH:       width_reg  = v[DIM_W-1:0];
            REG_FRAME_HEIGHT:      height_reg = v[DIM_W-1:0];
            REG_CHANNEL_COUNT:     chan_reg   = v[CHAN_W-1:0];
            REG_CHANNEL_TOLERANCE: tol_reg    = v[TOL_W-1:0];
            default: ;
         endcase
      endfunction

      function bit pair_mismatch(logic [PIXEL_W-1:0] a, logic [PIXEL_W-1:0] b);
         int unsigned n;
         int da, db;
         n = (chan_reg > MAX_CHANNELS) ? MAX_CHANNELS : chan_reg;
         for (int k = 0; k < n; k++) begin
            da = a[8*k +: 8];
            db = b[8*k +: 8];
            if ((da > db ? da - db : db - da) > tol_reg) return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_pixel(req_data_type d);
         int unsigned ew, eh, total;
         bit last_c, last_r, first;
         longint unsigned matching, frac;
         rsp_data_type r;
         ew = eff_dim(width_reg);
         eh = eff_dim(height_reg);
         // counters past the last index count as on it (shrunk mid-frame)
         last_c = col >= ew - 1;
         last_r = row >= eh - 1;
         if (pair_mismatch(d.pixel_a, d.pixel_b)) begin
            first = (differ == 0);
            if (differ < COUNT_MAX) differ++;
            if (first || col < min_c) min_c = col;
            if (first || row < min_r) min_r = row;
            if (first || col > max_c) max_c = col;
            if (first || row > max_r) max_r = row;
         end
         if (!last_c) begin
            col++;
            return;
         end
         if (!last_r) begin
            col = 0;
            row++;
            return;
         end
         total = ew * eh;
         matching = (differ >= total) ? 0 : total - differ;
         frac = (matching << 16) / total;
         r.diff_count     = differ;
         r.has_box        = (differ != 0);
         r.box_x          = r.has_box ? min_c : 0;
         r.box_y          = r.has_box ? min_r : 0;
         r.box_width      = r.has_box ? (max_c - min_c + 1) : 0;
         r.box_height     = r.has_box ? (max_r - min_r + 1) : 0;
         r.match_fraction = frac;
         frame_results.push_back(r);
         clear_frame();
      endfunction

      function void compare(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_data_type got);
         rsp_data_type want;
         if (frame_results.size() == 0) begin
            $display("%0t: result beat with nothing expected, actual %p", $time, got);
            errors++;
            return;
         end
         want = frame_results.pop_front();
         checked++;
         compare("diff_count", want.diff_count, got.diff_count);
         compare("has_box", want.has_box, got.has_box);
         compare("box_x", want.box_x, got.box_x);
         compare("box_y", want.box_y, got.box_y);
         compare("box_width", want.box_width, got.box_width);
         compare("box_height", want.box_height, got.box_height);
         compare("match_fraction", want.match_fraction, got.match_fraction);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_data_type           req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_data_type           rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   frame_stats_board frame_stats = new();
   bit hold_request = 1'b0;
   bit quiet = 1'b0;
   int unsigned cycles = 0;

   image_pair_diff_stats_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) frame_stats.check_result(rsp_data);
   end

   // result side: random stalls, one long hold on request, none when quiet
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_request = 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // pixel pair, equal unless the diff_odds draw hits; differing bytes mostly land near the tolerance edge
   function automatic req_data_type make_pair(int unsigned diff_odds, int unsigned tol);
      req_data_type p;
      int v, lim;
      p.pixel_a = $urandom();
      p.pixel_b = p.pixel_a;
      if (diff_odds != 0 && $urandom_range(1, diff_odds) == 1) begin
         if ($urandom_range(0, 7) == 0) begin
            p.pixel_b = $urandom();
         end else begin
            lim = tol + 2;
            for (int k = 0; k < 4; k++) begin
               if ($urandom_range(0, 2) == 0) begin
                  v = p.pixel_a[8*k +: 8];
                  v = v + int'($urandom_range(0, 2 * lim)) - lim;
                  if (v < 0) v = 0;
                  if (v > 255) v = 255;
                  p.pixel_b[8*k +: 8] = v[7:0];
               end
            end
         end
      end
      return p;
   endfunction

   task automatic send_pixel(input req_data_type d, input bit allow_gap);
      if (allow_gap && !quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (!req_ready);
      frame_stats.note_pixel(d);
      @(negedge clock);
   endtask

   task automatic send_pair(input logic [31:0] a, input logic [31:0] b);
      req_data_type d;
      d.pixel_a = a;
      d.pixel_b = b;
      send_pixel(d, 1'b1);
   endtask

   // wait out every expected frame result and the divider tail
   task automatic settle_idle();
      req_valid <= 1'b0;
      while (frame_stats.pending() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input int unsigned v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      frame_stats.write_reg(idx, v[CSR_DATA_W-1:0]);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_frame(input int unsigned w, input int unsigned h,
                            input int unsigned ch, input int unsigned tol);
      settle_idle();
      write_reg(REG_FRAME_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
      write_reg(REG_CHANNEL_COUNT, ch);
      write_reg(REG_CHANNEL_TOLERANCE, tol);
   endtask

   task automatic stream_frames(input int unsigned frames, input int unsigned diff_odds,
                                input bit allow_gap, inout int unsigned count);
      int unsigned n;
      n = frames * frame_stats.frame_pixels();
      repeat (n) begin
         send_pixel(make_pair(diff_odds, frame_stats.tol_reg), allow_gap);
         count++;
      end
   endtask

   initial begin
      int unsigned items, w, h, ch, tol, odds, pick;
      items = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= REG_FRAME_WIDTH;
      csr_data  <= '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // one 3x2 frame: extremes and channels 0, 2 and 3 each on their own
      set_frame(3, 2, 4, 0);
      send_pair(32'h0000_0000, 32'h0000_0000);
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pair(32'h0000_0000, 32'hFFFF_FFFF);
      send_pair(32'h0000_0001, 32'h0000_0000);
      send_pair(32'h00FF_0000, 32'h0000_0000);
      send_pair(32'h0100_0000, 32'h0000_0000);

      // zero width and height act as one pixel, so every beat ends a frame
      set_frame(0, 0, 1, 254);
      send_pair(32'h0000_0000, 32'h0000_00FF);
      send_pair(32'h1234_5600, 32'hEDCB_A900);
      set_frame(0, 0, 4, 255);
      send_pair(32'h0000_0000, 32'hFFFF_FFFF);
      // no channels compared, then a count above the maximum
      set_frame(0, 0, 0, 0);
      send_pair(32'h0000_0000, 32'hFFFF_FFFF);
      set_frame(0, 0, 7, 0);
      send_pair(32'h0000_0000, 32'h8000_0000);

      // shrink mid-frame: row counter already past the new last row, column on the new last column
      set_frame(4, 4, 4, 0);
      repeat (9) send_pair($urandom() & 32'h7F7F_7F7F, 32'hFFFF_FFFF);
      settle_idle();
      write_reg(REG_FRAME_WIDTH, 2);
      write_reg(REG_FRAME_HEIGHT, 1);
      send_pair(32'h0000_0000, 32'h0000_0000);

      for (int phase = 0; items < 1400 || frame_stats.checked < 60; phase++) begin
         pick = $urandom_range(0, 7);
         w = (pick == 0) ? $urandom_range(9, 32) : $urandom_range(0, 8);
         h = $urandom_range(0, 5);
         pick = $urandom_range(0, 9);
         ch = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(5, 7) : $urandom_range(1, 4);
         pick = $urandom_range(0, 3);
         tol = (pick == 0) ? 0 : (pick == 1) ? 255 :
               (pick == 2) ? $urandom_range(1, 8) : $urandom_range(0, 255);
         pick = $urandom_range(0, 3);
         odds = (pick == 0) ? 0 : (pick == 1) ? 1 : (pick == 2) ? 3 : 12;
         if (items > 1150) quiet = 1'b1;
         if (phase == 3) begin
            // single-pixel frames against a stalled receiver fill the block
            set_frame(1, 1, ch, tol);
            hold_request = 1'b1;
            stream_frames(40, 2, 1'b0, items);
         end else begin
            set_frame(w, h, ch, tol);
            stream_frames($urandom_range(1, 4), odds, 1'b1, items);
         end
      end

      settle_idle();
      frame_stats.errors += frame_stats.pending();
      if (frame_stats.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
design/ipds_pkg.sv
design/ipds_csr.sv
design/ipds_ctrl.sv
design/ipds_datapath.sv
design/image_pair_diff_stats_top.sv
test/image_pair_diff_stats_top_test.sv
